>>> hw/rtl/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared types and constants for the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package pmd_pkg;

  // Header byte bit positions
  localparam int unsigned HDR_LEFT_BIT   = 0;
  localparam int unsigned HDR_RIGHT_BIT  = 1;
  localparam int unsigned HDR_MIDDLE_BIT = 2;
  localparam int unsigned HDR_SYNC_BIT   = 3;
  localparam int unsigned HDR_XSIGN_BIT  = 4;
  localparam int unsigned HDR_YSIGN_BIT  = 5;
  localparam int unsigned HDR_XOVF_BIT   = 6;
  localparam int unsigned HDR_YOVF_BIT   = 7;

  // Event kinds
  localparam logic KIND_MOTION = 1'b0;
  localparam logic KIND_BUTTON = 1'b1;

  // Button identifiers
  localparam logic [1:0] BTN_LEFT   = 2'd0;
  localparam logic [1:0] BTN_RIGHT  = 2'd1;
  localparam logic [1:0] BTN_MIDDLE = 2'd2;

  // Byte positions within a packet
  localparam logic [1:0] POS_HEADER = 2'd0;
  localparam logic [1:0] POS_X      = 2'd1;
  localparam logic [1:0] POS_Y      = 2'd2;

  // Decoded packet handed from front to back
  typedef struct packed {
    logic              motion;   // motion event pending
    logic signed [8:0] dx;
    logic signed [9:0] dy;       // already negated, down positive
    logic [2:0]        buttons;  // new button state
    logic [2:0]        diff;     // buttons that changed
  } pkt_t;

endpackage

>>> hw/rtl/pmd_front.sv
// ----------------------------------------------------------------------------
// pmd_front
// Byte assembly: resync, header/X hold, delta formation, button change mask.
// ----------------------------------------------------------------------------
module pmd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic          cfg_wr_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_rx_byte,
  output logic          q_push,
  output pmd_pkg::pkt_t q_wdata,
  input  logic          q_ready
);
  import pmd_pkg::*;

  logic        enable_r;
  logic [1:0]  pos_r, pos_nxt;
  logic [7:0]  hdr_r;
  logic [7:0]  x_r;
  logic [2:0]  prev_r, prev_nxt;
  logic        accept;
  logic        complete;
  logic        ovf;
  logic signed [8:0] dx;
  logic signed [8:0] dy9;
  logic signed [9:0] dy_neg;
  logic [2:0]  buttons;
  logic [2:0]  diff;
  logic        motion;

  // only the completing beat needs queue space
  assign in_ready = !pos_r[1] || q_ready;
  assign accept   = in_valid && in_ready;
  assign complete = accept && pos_r[1];

  assign ovf     = hdr_r[HDR_XOVF_BIT] || hdr_r[HDR_YOVF_BIT];
  assign dx      = ovf ? 9'sd0 : $signed({hdr_r[HDR_XSIGN_BIT], x_r});
  assign dy9     = ovf ? 9'sd0 : $signed({hdr_r[HDR_YSIGN_BIT], in_rx_byte});
  assign dy_neg  = -10'(dy9);
  assign buttons = hdr_r[HDR_MIDDLE_BIT:HDR_LEFT_BIT];
  assign diff    = buttons ^ prev_r;
  assign motion  = (dx != 9'sd0) || (dy9 != 9'sd0);

  assign q_push          = complete && enable_r && (motion || (diff != 3'b000));
  assign q_wdata.motion  = motion;
  assign q_wdata.dx      = dx;
  assign q_wdata.dy      = dy_neg;
  assign q_wdata.buttons = buttons;
  assign q_wdata.diff    = diff;

  always_comb begin
    pos_nxt  = pos_r;
    prev_nxt = prev_r;
    if (accept) begin
      priority if (pos_r == POS_HEADER) begin
        if (in_rx_byte[HDR_SYNC_BIT]) pos_nxt = POS_X;
      end else if (pos_r == POS_X) begin
        pos_nxt = POS_Y;
      end else begin
        pos_nxt = POS_HEADER;
        if (enable_r) prev_nxt = buttons;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      pos_r    <= POS_HEADER;
      prev_r   <= 3'b000;
    end else begin
      if (cfg_wr_en) enable_r <= cfg_wr_data;
      pos_r  <= pos_nxt;
      prev_r <= prev_nxt;
    end
  end

  // held bytes, no reset
  always_ff @(posedge clk) begin
    if (accept && pos_r == POS_HEADER && in_rx_byte[HDR_SYNC_BIT]) hdr_r <= in_rx_byte;
    if (accept && pos_r == POS_X) x_r <= in_rx_byte;
  end

endmodule

>>> hw/rtl/pmd_queue.sv
// ----------------------------------------------------------------------------
// pmd_queue
// Two-entry packet queue between front and back.
// ----------------------------------------------------------------------------
module pmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pmd_pkg::pkt_t wdata,
  output logic          wready,
  input  logic          pop,
  output pmd_pkg::pkt_t rdata,
  output logic          rvalid
);
  import pmd_pkg::*;

  pkt_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign wready  = (count_r != 2'd2);
  assign rvalid  = (count_r != 2'd0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && wready;
  assign do_pop  = pop && rvalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

>>> hw/rtl/pmd_back.sv
// ----------------------------------------------------------------------------
// pmd_back
// Event sequencer: expands one packet into motion and button beats.
// ----------------------------------------------------------------------------
module pmd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  pmd_pkg::pkt_t     q_rdata,
  input  logic              q_rvalid,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_event_kind,
  output logic signed [8:0] out_move_x,
  output logic signed [9:0] out_move_y,
  output logic [1:0]        out_button_id,
  output logic              out_pressed,
  output logic              out_last_event
);
  import pmd_pkg::*;

  pkt_t        cur_r;
  logic [3:0]  pend_r, pend_nxt;   // bit0 motion, bits 3:1 left/right/middle
  logic [3:0]  sel;
  logic [3:0]  pend_after;
  logic        out_free;
  logic        emit;
  logic        emit_last;

  logic              valid_r, valid_nxt;
  logic              kind_r, kind_nxt;
  logic signed [8:0] mx_r, mx_nxt;
  logic signed [9:0] my_r, my_nxt;
  logic [1:0]        id_r, id_nxt;
  logic              prs_r, prs_nxt;
  logic              last_r, last_nxt;

  assign out_free   = !valid_r || out_ready;
  assign emit       = out_free && (pend_r != 4'b0000);
  assign q_pop      = (pend_r == 4'b0000) && q_rvalid;
  assign sel        = pend_r & (~pend_r + 4'd1);   // lowest pending
  assign pend_after = pend_r & ~sel;
  assign emit_last  = (pend_after == 4'b0000);

  always_comb begin
    pend_nxt  = pend_r;
    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    mx_nxt    = mx_r;
    my_nxt    = my_r;
    id_nxt    = id_r;
    prs_nxt   = prs_r;
    last_nxt  = last_r;
    if (q_pop) begin
      pend_nxt = {q_rdata.diff, q_rdata.motion};
    end else if (emit) begin
      pend_nxt = pend_after;
    end
    if (emit) begin
      valid_nxt = 1'b1;
      last_nxt  = emit_last;
      priority if (sel[0]) begin
        kind_nxt = KIND_MOTION;
        mx_nxt   = cur_r.dx;
        my_nxt   = cur_r.dy;
        id_nxt   = BTN_LEFT;
        prs_nxt  = 1'b0;
      end else if (sel[1]) begin
        kind_nxt = KIND_BUTTON;
        mx_nxt   = 9'sd0;
        my_nxt   = 10'sd0;
        id_nxt   = BTN_LEFT;
        prs_nxt  = cur_r.buttons[HDR_LEFT_BIT];
      end else if (sel[2]) begin
        kind_nxt = KIND_BUTTON;
        mx_nxt   = 9'sd0;
        my_nxt   = 10'sd0;
        id_nxt   = BTN_RIGHT;
        prs_nxt  = cur_r.buttons[HDR_RIGHT_BIT];
      end else begin
        kind_nxt = KIND_BUTTON;
        mx_nxt   = 9'sd0;
        my_nxt   = 10'sd0;
        id_nxt   = BTN_MIDDLE;
        prs_nxt  = cur_r.buttons[HDR_MIDDLE_BIT];
      end
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 4'b0000;
      valid_r <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_rdata;
    kind_r <= kind_nxt;
    mx_r   <= mx_nxt;
    my_r   <= my_nxt;
    id_r   <= id_nxt;
    prs_r  <= prs_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = valid_r;
  assign out_event_kind = kind_r;
  assign out_move_x     = mx_r;
  assign out_move_y     = my_r;
  assign out_button_id  = id_r;
  assign out_pressed    = prs_r;
  assign out_last_event = last_r;

`ifndef SYNTHESIS
  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (pend_r != 4'b0000))
    else $error("queued packet carried no event");

  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_last) |=> (pend_r == 4'b0000))
    else $error("last beat sent with events still pending");

  a_button_no_motion: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && kind_r == KIND_BUTTON) |-> (mx_r == 9'sd0 && my_r == 10'sd0))
    else $error("button beat carries motion");
`endif

endmodule

>>> hw/rtl/ps2_mouse_packet_decoder.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// Turns a received PS/2 mouse byte stream into motion and button beats.
// ----------------------------------------------------------------------------
// Feed received bytes on the in_ channel; events come out on the out_ channel.
// A byte at packet start with bit 3 clear is dropped to regain framing. On the
// third byte of a packet, with cfg reporting enabled, the block yields up to
// four beats: a motion beat (Y negated, down positive) when either delta is
// non-zero, then one beat per changed button in the order left, right,
// middle; out_last_event marks the final beat of the packet. Overflow zeroes
// motion but buttons still report. With reporting off, packets are consumed
// silently and the button history is left alone. Input bytes are taken one
// per cycle; the event sequencer fetches each packet from the two-entry
// packet queue, emits its beats as the output accepts them and finishes
// it before fetching the next, and the input only stalls on a third byte
// while that queue is full. Write cfg_wr_data only while the block is idle.
module ps2_mouse_packet_decoder (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,    // reporting enabled
  // received bytes
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  // events
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_event_kind,
  output logic signed [8:0] out_move_x,
  output logic signed [9:0] out_move_y,
  output logic [1:0]        out_button_id,
  output logic              out_pressed,
  output logic              out_last_event
);
  import pmd_pkg::*;

  // front -> queue
  logic q_push;
  pkt_t q_wdata;
  logic q_wready;
  // queue -> back
  pkt_t q_rdata;
  logic q_rvalid;
  logic q_pop;

  // Front: framing, held bytes, deltas, button change mask
  pmd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_rx_byte  (in_rx_byte),
    .q_push      (q_push),
    .q_wdata     (q_wdata),
    .q_ready     (q_wready)
  );

  // Decoupling queue: only packets that produce at least one beat enter it
  pmd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .wready (q_wready),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .rvalid (q_rvalid)
  );

  // Back: one beat per cycle while the output accepts, into a registered output stage
  pmd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_rdata        (q_rdata),
    .q_rvalid       (q_rvalid),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_move_x     (out_move_x),
    .out_move_y     (out_move_y),
    .out_button_id  (out_button_id),
    .out_pressed    (out_pressed),
    .out_last_event (out_last_event)
  );

endmodule
